// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/core/wsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  localparam logic [3:0] OPC_TEXT   = 4'd1;
  localparam logic [3:0] OPC_BINARY = 4'd2;
  localparam logic [3:0] OPC_PING   = 4'd9;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [3:0] frame_opcode;
    logic       deliver;
    logic       frame_end;
    logic       pong_due;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// WebSocket receive-side deframer. Feed the raw stream after the handshake on
// the in_ channel, one byte per item. Header bytes (opcode, length code,
// extended length, mask key) are absorbed; each payload byte leaves on the
// out_ channel unmasked and tagged with the frame opcode, a deliver flag for
// text or binary frames, frame_end on the last item, and pong_due at the end
// of a ping frame. A frame of zero length gives one item with has_byte low.
// Each result is registered in the output buffer before it appears on out_.
// Throughput: one byte per cycle while in_ready is high; the parser updates
// its state in the same cycle it accepts a byte, and a two-entry output buffer
// keeps in_ready high while one result waits. If the receiver stalls, the
// buffer fills and in_ready drops; it rises again once an item is taken.
// Reset (synchronous, active low) returns the parser to expecting a frame's
// first header byte and empties the output buffer. LENGTH_BITS sets the width
// of the length counter; larger frame lengths saturate to its maximum.
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_rx_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_byte,
  output logic [3:0]  out_frame_opcode,
  output logic        out_deliver,
  output logic        out_frame_end,
  output logic        out_pong_due
);

  logic              in_fire;
  logic              res_valid;
  wsfd_pkg::result_t res;
  wsfd_pkg::result_t out_r;
  wsfd_pkg::result_t skid_r;
  logic              out_v_r;
  logic              skid_v_r;

  assign in_ready = ~skid_v_r;
  assign in_fire  = in_valid & in_ready;

  wsfd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_fire),
    .rx_byte    (in_rx_byte),
    .res_valid  (res_valid),
    .res        (res)
  );

  // While the skid entry is full no byte is accepted, so a new result and a
  // parked one never compete for the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r | res_valid;
      skid_v_r <= 1'b0;
    end else if (res_valid) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_has_byte     = out_r.has_byte;
  assign out_frame_opcode = out_r.frame_opcode;
  assign out_deliver      = out_r.deliver;
  assign out_frame_end    = out_r.frame_end;
  assign out_pong_due     = out_r.pong_due;

endmodule

`default_nettype wire

// ===== rtl/core/wsfd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsfd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                byte_valid,
  input  wire  [7:0]         rx_byte,
  output logic               res_valid,
  output wsfd_pkg::result_t  res
);

  wsfd_pkg::phase_t       phase_r, phase_nxt;
  logic [3:0]             hdr_cnt_r, hdr_cnt_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   masked_r, masked_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             key_idx_r, key_idx_nxt;

  logic [LENGTH_BITS-1:0] len_shift;
  logic [LENGTH_BITS-1:0] len_final;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   ovf_shift;
  logic [3:0]             hdr_cnt_dec;
  logic [7:0]             key_byte;
  logic                   emit;
  logic                   emit_data;
  logic                   emit_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsfd_pkg::PH_FIRST;
      hdr_cnt_r <= '0;
      opcode_r  <= '0;
      masked_r  <= 1'b0;
      rem_r     <= '0;
      ovf_r     <= 1'b0;
      key_r     <= '0;
      key_idx_r <= '0;
    end else if (byte_valid) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      opcode_r  <= opcode_nxt;
      masked_r  <= masked_nxt;
      rem_r     <= rem_nxt;
      ovf_r     <= ovf_nxt;
      key_r     <= key_nxt;
      key_idx_r <= key_idx_nxt;
    end
  end

  // Extended length bytes shift in big-endian; any bit that would fall off the
  // top marks the length as too large, and it saturates when complete.
  assign len_shift   = {rem_r[LENGTH_BITS-9:0], rx_byte};
  assign ovf_shift   = ovf_r | (rem_r[LENGTH_BITS-1 -: 8] != 8'd0);
  assign len_final   = ovf_shift ? '1 : len_shift;
  assign hdr_cnt_dec = (hdr_cnt_r != 4'd0) ? hdr_cnt_r - 4'd1 : hdr_cnt_r;
  assign rem_dec     = (rem_r != '0) ? rem_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1} : rem_r;
  // Key byte 0 sits in the top eight bits.
  assign key_byte    = key_r[{~key_idx_r, 3'b000} +: 8];

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    opcode_nxt  = opcode_r;
    masked_nxt  = masked_r;
    rem_nxt     = rem_r;
    ovf_nxt     = ovf_r;
    key_nxt     = key_r;
    key_idx_nxt = key_idx_r;
    emit        = 1'b0;
    emit_data   = 1'b0;
    emit_end    = 1'b0;

    case (phase_r)
      wsfd_pkg::PH_SECOND: begin
        masked_nxt  = rx_byte[7];
        key_nxt     = '0;
        key_idx_nxt = '0;
        ovf_nxt     = 1'b0;
        rem_nxt     = {{(LENGTH_BITS-7){1'b0}}, rx_byte[6:0]};
        if (rx_byte[6:0] == wsfd_pkg::LEN_CODE_16) begin
          rem_nxt     = '0;
          hdr_cnt_nxt = wsfd_pkg::EXT16_BYTES;
          phase_nxt   = wsfd_pkg::PH_EXTLEN;
        end else if (rx_byte[6:0] == wsfd_pkg::LEN_CODE_64) begin
          rem_nxt     = '0;
          hdr_cnt_nxt = wsfd_pkg::EXT64_BYTES;
          phase_nxt   = wsfd_pkg::PH_EXTLEN;
        end else if (rx_byte[7]) begin
          hdr_cnt_nxt = wsfd_pkg::KEY_BYTES;
          phase_nxt   = wsfd_pkg::PH_KEY;
        end else if (rx_byte[6:0] == 7'd0) begin
          emit      = 1'b1;
          emit_end  = 1'b1;
          phase_nxt = wsfd_pkg::PH_FIRST;
        end else begin
          phase_nxt = wsfd_pkg::PH_PAYLOAD;
        end
      end
      wsfd_pkg::PH_EXTLEN: begin
        hdr_cnt_nxt = hdr_cnt_dec;
        ovf_nxt     = ovf_shift;
        rem_nxt     = len_shift;
        if (hdr_cnt_dec == 4'd0) begin
          rem_nxt = len_final;
          if (masked_r) begin
            hdr_cnt_nxt = wsfd_pkg::KEY_BYTES;
            phase_nxt   = wsfd_pkg::PH_KEY;
          end else if (len_final == '0) begin
            emit      = 1'b1;
            emit_end  = 1'b1;
            phase_nxt = wsfd_pkg::PH_FIRST;
          end else begin
            phase_nxt = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_KEY: begin
        key_nxt     = {key_r[23:0], rx_byte};
        hdr_cnt_nxt = hdr_cnt_dec;
        if (hdr_cnt_dec == 4'd0) begin
          if (rem_r == '0) begin
            emit      = 1'b1;
            emit_end  = 1'b1;
            phase_nxt = wsfd_pkg::PH_FIRST;
          end else begin
            phase_nxt = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        key_idx_nxt = key_idx_r + 2'd1;
        rem_nxt     = rem_dec;
        emit        = 1'b1;
        emit_data   = 1'b1;
        emit_end    = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_nxt = wsfd_pkg::PH_FIRST;
        end
      end
      default: begin
        opcode_nxt = rx_byte[3:0];
        phase_nxt  = wsfd_pkg::PH_SECOND;
      end
    endcase
  end

  assign res_valid        = byte_valid & emit;
  assign res.payload_byte = emit_data ? (rx_byte ^ key_byte) : 8'd0;
  assign res.has_byte     = emit_data;
  assign res.frame_opcode = opcode_r;
  assign res.deliver      = (opcode_r == wsfd_pkg::OPC_TEXT) ||
                            (opcode_r == wsfd_pkg::OPC_BINARY);
  assign res.frame_end    = emit_end;
  assign res.pong_due     = emit_end && (opcode_r == wsfd_pkg::OPC_PING);

endmodule

`default_nettype wire

// ===== rtl/core/wsfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wsfd_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_payload_byte,
  input wire       out_has_byte,
  input wire [3:0] out_frame_opcode,
  input wire       out_deliver,
  input wire       out_frame_end,
  input wire       out_pong_due
);

  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

  `ASSERT_CLK(a_stall_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) &&
    $stable(out_frame_end),
    "stalled item changed")

  `ASSERT_CLK(a_empty_end, clk, rst_n,
    out_valid && !out_has_byte |-> out_frame_end && out_payload_byte == 8'd0,
    "empty item is not a clean frame end")

  `ASSERT_CLK(a_pong_ping, clk, rst_n,
    out_valid && out_pong_due |-> out_frame_end && out_frame_opcode == wsfd_pkg::OPC_PING,
    "pong request outside a ping frame end")

  `ASSERT_CLK(a_deliver_op, clk, rst_n,
    out_valid |-> out_deliver == (out_frame_opcode == wsfd_pkg::OPC_TEXT ||
    out_frame_opcode == wsfd_pkg::OPC_BINARY),
    "deliver flag disagrees with opcode")

endmodule

bind websocket_frame_deframer wsfd_checker u_wsfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_payload_byte (out_payload_byte),
  .out_has_byte     (out_has_byte),
  .out_frame_opcode (out_frame_opcode),
  .out_deliver      (out_deliver),
  .out_frame_end    (out_frame_end),
  .out_pong_due     (out_pong_due)
);

`default_nettype wire
